@@ rtl/sdsrf_pkg.sv @@
package sdsrf_pkg;

   // Command codes carried in req_tuser.
   localparam logic [1:0] CMD_START_RESP  = 2'd0;
   localparam logic [1:0] CMD_START_BLOCK = 2'd1;
   localparam logic [1:0] CMD_BYTE        = 2'd2;

   // Result kinds carried in rsp_tuser.
   localparam logic [1:0] KIND_RESPONSE = 2'd0;
   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] KIND_CRC      = 2'd2;

   // Framer phases.
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_RESP_HUNT = 3'd1;
   localparam logic [2:0] PH_RESP_BODY = 3'd2;
   localparam logic [2:0] PH_BLK_HUNT  = 3'd3;
   localparam logic [2:0] PH_BLK_DATA  = 3'd4;
   localparam logic [2:0] PH_CRC_HI    = 3'd5;
   localparam logic [2:0] PH_CRC_LO    = 3'd6;

   localparam logic [7:0] START_TOKEN = 8'hFE;
   localparam int         BUSY_BIT    = 7;
   localparam logic [2:0] RESP_LEN_MIN = 3'd1;
   localparam logic [2:0] RESP_LEN_MAX = 3'd5;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] resp_bytes;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [39:0] response_value;
      logic [7:0]  data_value;
      logic [8:0]  byte_index;
      logic [15:0] block_crc;
   } rsp_item_type;

endpackage

@@ rtl/sdsrf_core.sv @@
module sdsrf_core #(
   parameter int BLOCK_BYTES = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  sdsrf_pkg::req_item_type req,
   output logic                   res_valid,
   output sdsrf_pkg::rsp_item_type res
);
   import sdsrf_pkg::*;

   localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_BYTES);

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] blk_count_ff, blk_count_in;
   logic [2:0]       resp_count_ff, resp_count_in;
   logic [2:0]       wanted_len_ff, wanted_len_in;
   logic [39:0]      shift_ff, shift_in;
   logic [7:0]       crc_high_ff, crc_high_in;
   logic             emit;

   always_comb begin
      phase_in      = phase_ff;
      blk_count_in  = blk_count_ff;
      resp_count_in = resp_count_ff;
      wanted_len_in = wanted_len_ff;
      shift_in      = shift_ff;
      crc_high_in   = crc_high_ff;
      emit          = 1'b0;
      res           = '0;

      case (req.cmd)
         CMD_START_RESP: begin
            if (req.resp_bytes < RESP_LEN_MIN) begin
               wanted_len_in = RESP_LEN_MIN;
            end else if (req.resp_bytes > RESP_LEN_MAX) begin
               wanted_len_in = RESP_LEN_MAX;
            end else begin
               wanted_len_in = req.resp_bytes;
            end
            resp_count_in = '0;
            phase_in      = PH_RESP_HUNT;
         end
         CMD_START_BLOCK: begin
            blk_count_in = '0;
            phase_in     = PH_BLK_HUNT;
         end
         CMD_BYTE: begin
            unique case (phase_ff)
               PH_RESP_HUNT: begin
                  // Bytes with the busy bit set are filler ahead of the response.
                  if (!req.rx_byte[BUSY_BIT]) begin
                     shift_in      = {32'd0, req.rx_byte};
                     resp_count_in = 3'd1;
                     phase_in      = PH_RESP_BODY;
                  end
               end
               PH_RESP_BODY: begin
                  shift_in      = {shift_ff[31:0], req.rx_byte};
                  resp_count_in = resp_count_ff + 3'd1;
               end
               PH_BLK_HUNT: begin
                  if (req.rx_byte == START_TOKEN) begin
                     blk_count_in = '0;
                     phase_in     = PH_BLK_DATA;
                  end
               end
               PH_BLK_DATA: begin
                  emit           = 1'b1;
                  res.kind       = KIND_DATA;
                  res.data_value = req.rx_byte;
                  res.byte_index = 9'(blk_count_ff);
                  blk_count_in   = blk_count_ff + 1'b1;
                  if (blk_count_in == CNT_LAST) begin
                     phase_in = PH_CRC_HI;
                  end
               end
               PH_CRC_HI: begin
                  crc_high_in = req.rx_byte;
                  phase_in    = PH_CRC_LO;
               end
               PH_CRC_LO: begin
                  emit          = 1'b1;
                  res.kind      = KIND_CRC;
                  res.block_crc = {crc_high_ff, req.rx_byte};
                  phase_in      = PH_IDLE;
               end
               default: begin
               end
            endcase

            // The response is complete once the byte that reaches the wanted length arrives.
            if ((phase_ff == PH_RESP_BODY || phase_in == PH_RESP_BODY)
                && resp_count_in >= wanted_len_ff) begin
               emit               = 1'b1;
               res.kind           = KIND_RESPONSE;
               res.response_value = shift_in;
               phase_in           = PH_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   assign res_valid = step & emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         blk_count_ff  <= '0;
         resp_count_ff <= '0;
         wanted_len_ff <= RESP_LEN_MIN;
      end else if (step) begin
         phase_ff      <= phase_in;
         blk_count_ff  <= blk_count_in;
         resp_count_ff <= resp_count_in;
         wanted_len_ff <= wanted_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         shift_ff    <= shift_in;
         crc_high_ff <= crc_high_in;
      end
   end

`ifndef SYNTHESIS
   a_index_in_block: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_DATA |-> 32'(res.byte_index) < BLOCK_BYTES)
      else $error("data byte index beyond block length");

   a_crc_after_block: assert property (@(posedge clock) disable iff (reset)
      step && req.cmd == CMD_BYTE && phase_ff == PH_BLK_DATA
      && 32'(blk_count_ff) == BLOCK_BYTES - 1 |=> phase_ff == PH_CRC_HI)
      else $error("last data byte did not move the framer to the crc");

   a_resp_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RESP_BODY |-> resp_count_ff < wanted_len_ff
      && wanted_len_ff <= RESP_LEN_MAX)
      else $error("response byte count out of range");

   a_blk_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BLK_DATA |-> 32'(blk_count_ff) < BLOCK_BYTES)
      else $error("block byte count out of range");
`endif

endmodule

@@ rtl/sd_spi_receive_framer.sv @@
// Receive framer for an SD card in SPI mode. Each request item is either a
// start command (tuser 0: capture a response of resp_bytes bytes, tuser 1:
// capture a data block) or one byte from the card (tuser 2). A response item
// gives the packed response, first byte most significant; a block gives one
// item per data byte with its index, then one item with the 16-bit CRC as
// received. Each request item is handled at the edge that accepts it: the
// framer state updates at that edge and its result, if any, is loaded into
// the output register at the same edge. A new item is taken every cycle
// while the output register is empty or is being drained in that same cycle,
// so the sustained rate is one item per clock with rsp_tready held high.
module sd_spi_receive_framer #(
   parameter int BLOCK_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // resp_bytes [2:0], rx_byte [10:3]
   input  logic [1:0]  req_tuser,   // cmd [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // response_value [39:0], data_value [47:40],
                                    // byte_index [56:48], block_crc [72:57]
   output logic [1:0]  rsp_tuser    // kind [1:0]
);
   import sdsrf_pkg::*;

   req_item_type req;
   rsp_item_type res;
   logic         res_valid;
   logic         step;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   assign req.cmd        = req_tuser;
   assign req.resp_bytes = req_tdata[2:0];
   assign req.rx_byte    = req_tdata[10:3];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   sdsrf_core #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req      (req),
      .res_valid(res_valid),
      .res      (res)
   );

   always_comb begin
      if (step) begin
         rsp_valid_in = res_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.kind;
   assign rsp_tdata  = {7'd0, rsp_item_ff.block_crc, rsp_item_ff.byte_index,
                        rsp_item_ff.data_value, rsp_item_ff.response_value};

endmodule
